// ===== rtl/core/tcg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcg_pkg
// Shared constants for the texture coordinate generator: default widths,
// mapping mode codes and configuration register indexes.
// ----------------------------------------------------------------------------
package tcg_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int DEF_WORD_BITS = 32;
    localparam int TEX_BITS      = 16;
    localparam int CFG_IDX_BITS  = 3;

    localparam logic [1:0] MODE_WORLD    = 2'd0;
    localparam logic [1:0] MODE_INSTANCE = 2'd1;
    localparam logic [1:0] MODE_LINE     = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] REG_MAP_MODE   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Y   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_TEX_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCALE_X    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCALE_Y    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_X   = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_Y   = 3'd7;

endpackage

// ===== rtl/core/texture_coordinate_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_coordinate_generator_core
// Turns a beat of vertex positions into one saturated texture coordinate.
// ----------------------------------------------------------------------------
// One vertex is in flight at a time; s_tready is high only while the block
// waits for a vertex. Each vertex passes through a restoring divider, and
// on the third and fourth corner of a quad in line mode also, before it,
// through a bit-serial multiplier and a two-bit-per-cycle square root. The
// divider produces one quotient bit per cycle and is shared by u and v.
// The result beat then waits in an output register until it is taken.
// ----------------------------------------------------------------------------
module texture_coordinate_generator_core #(
    parameter int FRAC_BITS = tcg_pkg::DEF_FRAC_BITS,
    parameter int WORD_BITS = tcg_pkg::DEF_WORD_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [tcg_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [WORD_BITS-1:0]                 cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // Fields from bit 0: pos_x, pos_y, zero fill.
    input  logic [((2*WORD_BITS+7)/8)*8-1:0]     s_tdata,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // Fields from bit 0: tex_u, tex_v, zero fill.
    output logic [((2*WORD_BITS+7)/8)*8-1:0]     m_tdata,
    output logic                                 m_tlast,
    // Fields from bit 0: divide_fault.
    output logic                                 m_tuser
);
    import tcg_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int MB  = (W + 1 > TEX_BITS + F) ? W + 1 : TEX_BITS + F;
    localparam int NB  = MB + 1;
    localparam int R   = W + 1;
    localparam int DL  = MB + F;
    localparam int CW  = $clog2(DL + 1);
    localparam int TW  = ((2*W+7)/8)*8;
    localparam logic [W-1:0] WSIGN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] WMAX  = {1'b0, {(W-1){1'b1}}};

    typedef enum logic [2:0] {
        ST_IDLE, ST_SQ, ST_RT, ST_DLD, ST_DIV, ST_FIN, ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic sel_reg, sel_next, last_reg, last_next, fault_reg, fault_next;
    logic [1:0] slot_cur_reg, slot_cur_next, quad_slot_reg, quad_slot_next;

    logic [1:0]   map_mode_reg;
    logic [W-1:0] origin_x_reg, origin_y_reg, scale_x_reg, scale_y_reg;
    logic [W-1:0] offset_x_reg, offset_y_reg;
    logic [TEX_BITS-1:0] tex_height_reg;

    logic [W-1:0] c0x_reg, c0x_next, c0y_reg, c0y_next;
    logic [W-1:0] c1x_reg, c1x_next, c1y_reg, c1y_next;
    logic [W-1:0] edge_a_reg, edge_a_next, line_off_reg, line_off_next;

    logic signed [NB-1:0] nu_reg, nu_next, nv_reg, nv_next;
    logic [W-1:0] mx_reg, mx_next, my_reg, my_next, dxm_reg, dxm_next, dym_reg, dym_next;
    logic [2*R-1:0] acc_reg, acc_next;
    logic [R+1:0] rem_reg, rem_next;
    logic [R-1:0] root_reg, root_next;
    logic [DL-1:0] dvd_reg, dvd_next;
    logic [W-1:0] rmd_reg, rmd_next, quo_reg, quo_next, dsr_reg, dsr_next;
    logic big_reg, big_next, neg_reg, neg_next, anz_reg, anz_next;
    logic [W-1:0] u_reg, u_next, v_reg, v_next;

    logic signed [W-1:0] px, py;
    logic signed [W:0] ddx, ddy;
    logic [W-1:0] cx, cy;
    logic [R+1:0] rem_t, trial;
    logic rt_ge, dv_ge;
    logic [W-1:0] e_len, e_min;
    logic [W:0] lo_sum, dv_t, dv_d;
    logic signed [NB-1:0] num, num_abs;
    logic [W-1:0] sc, off, qm;
    logic signed [W+1:0] sq, sum;
    logic [W-1:0] res;

    assign px = s_tdata[W-1:0];
    assign py = s_tdata[2*W-1:W];
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = TW'({v_reg, u_reg});
    assign m_tlast  = last_reg;
    assign m_tuser  = fault_reg;

    always_comb begin
        state_next = state_reg;  cnt_next = cnt_reg;  sel_next = sel_reg;
        last_next = last_reg;  fault_next = fault_reg;
        slot_cur_next = slot_cur_reg;  quad_slot_next = quad_slot_reg;
        c0x_next = c0x_reg;  c0y_next = c0y_reg;  c1x_next = c1x_reg;  c1y_next = c1y_reg;
        edge_a_next = edge_a_reg;  line_off_next = line_off_reg;
        nu_next = nu_reg;  nv_next = nv_reg;
        mx_next = mx_reg;  my_next = my_reg;  dxm_next = dxm_reg;  dym_next = dym_reg;
        acc_next = acc_reg;  rem_next = rem_reg;  root_next = root_reg;
        dvd_next = dvd_reg;  rmd_next = rmd_reg;  quo_next = quo_reg;  dsr_next = dsr_reg;
        big_next = big_reg;  neg_next = neg_reg;  anz_next = anz_reg;
        u_next = u_reg;  v_next = v_reg;

        cx = quad_slot_reg[0] ? c1x_reg : c0x_reg;
        cy = quad_slot_reg[0] ? c1y_reg : c0y_reg;
        ddx = {px[W-1], px} - {cx[W-1], cx};
        ddy = {py[W-1], py} - {cy[W-1], cy};

        rem_t = {rem_reg[R-1:0], acc_reg[2*R-1:2*R-2]};
        trial = {root_reg, 2'b01};
        rt_ge = (rem_t >= trial);
        e_len = '0;  e_min = '0;  lo_sum = '0;

        dv_t  = {rmd_reg, dvd_reg[DL-1]};
        dv_ge = (dv_t >= {1'b0, dsr_reg});
        dv_d  = dv_t - {1'b0, dsr_reg};

        num = sel_reg ? nv_reg : nu_reg;
        num_abs = num[NB-1] ? -num : num;
        sc  = sel_reg ? scale_y_reg : scale_x_reg;
        off = sel_reg ? offset_y_reg : offset_x_reg;
        if (dsr_reg == '0) begin
            qm = anz_reg ? WSIGN : '0;
        end else if (big_reg || (quo_reg > WSIGN)) begin
            qm = WSIGN;
        end else begin
            qm = quo_reg;
        end
        sq  = neg_reg ? -$signed({2'b00, qm}) : $signed({2'b00, qm});
        sum = sq + $signed({{2{off[W-1]}}, off});
        if (sum > $signed({3'b000, WMAX[W-2:0]})) begin
            res = WMAX;
        end else if (sum < -$signed({2'b00, WSIGN})) begin
            res = WSIGN;
        end else begin
            res = sum[W-1:0];
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    last_next = s_tlast;
                    fault_next = 1'b0;
                    sel_next = 1'b0;
                    cnt_next = '0;
                    slot_cur_next = quad_slot_reg;
                    state_next = ST_DLD;
                    if (map_mode_reg == MODE_INSTANCE) begin
                        nu_next = NB'(px);
                        nv_next = NB'(py);
                    end else if (map_mode_reg == MODE_LINE) begin
                        quad_slot_next = quad_slot_reg + 2'd1;
                        nu_next = $signed({{(NB-W){1'b0}}, line_off_reg});
                        nv_next = quad_slot_reg[0]
                            ? $signed(NB'({tex_height_reg, {F{1'b0}}})) : '0;
                        if (quad_slot_reg == 2'd0) begin
                            c0x_next = px;  c0y_next = py;
                        end else if (quad_slot_reg == 2'd1) begin
                            c1x_next = px;  c1y_next = py;
                        end else begin
                            dxm_next = ddx[W] ? W'(-ddx) : ddx[W-1:0];
                            dym_next = ddy[W] ? W'(-ddy) : ddy[W-1:0];
                            mx_next = ddx[W] ? W'(-ddx) : ddx[W-1:0];
                            my_next = ddy[W] ? W'(-ddy) : ddy[W-1:0];
                            acc_next = '0;
                            state_next = ST_SQ;
                        end
                    end else begin
                        nu_next = NB'(px) + NB'($signed(origin_x_reg));
                        nv_next = NB'(py) + NB'($signed(origin_y_reg));
                    end
                end
            end
            ST_SQ: begin
                acc_next = {acc_reg[2*R-2:0], 1'b0}
                    + (mx_reg[W-1] ? {{(2*R-W){1'b0}}, dxm_reg} : '0)
                    + (my_reg[W-1] ? {{(2*R-W){1'b0}}, dym_reg} : '0);
                mx_next = {mx_reg[W-2:0], 1'b0};
                my_next = {my_reg[W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1)) begin
                    cnt_next = '0;
                    rem_next = '0;
                    root_next = '0;
                    state_next = ST_RT;
                end
            end
            ST_RT: begin
                rem_next = rt_ge ? rem_t - trial : rem_t;
                root_next = {root_reg[R-2:0], rt_ge};
                acc_next = {acc_reg[2*R-3:0], 2'b00};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(R - 1)) begin
                    e_len = (root_next > {1'b0, WMAX}) ? WMAX : root_next[W-1:0];
                    e_min = (e_len < edge_a_reg) ? e_len : edge_a_reg;
                    lo_sum = {1'b0, line_off_reg} + {1'b0, e_min};
                    nu_next = $signed({{(NB-W){1'b0}}, line_off_reg})
                        + $signed({{(NB-W){1'b0}}, e_len});
                    if (slot_cur_reg == 2'd2) begin
                        edge_a_next = e_len;
                    end else begin
                        line_off_next = (lo_sum > {1'b0, WMAX}) ? WMAX : lo_sum[W-1:0];
                    end
                    cnt_next = '0;
                    state_next = ST_DLD;
                end
            end
            ST_DLD: begin
                dvd_next = {num_abs[MB-1:0], {F{1'b0}}};
                dsr_next = sc[W-1] ? W'(-sc) : sc;
                neg_next = num[NB-1] ^ sc[W-1];
                anz_next = (num != '0);
                rmd_next = '0;
                quo_next = '0;
                big_next = 1'b0;
                cnt_next = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rmd_next = dv_ge ? dv_d[W-1:0] : dv_t[W-1:0];
                dvd_next = {dvd_reg[DL-2:0], 1'b0};
                big_next = big_reg | quo_reg[W-1];
                quo_next = {quo_reg[W-2:0], dv_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(DL - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                fault_next = fault_reg | (dsr_reg == '0);
                if (!sel_reg) begin
                    u_next = res;
                    sel_next = 1'b1;
                    state_next = ST_DLD;
                end else begin
                    v_next = res;
                    state_next = ST_OUT;
                    if (last_reg) begin
                        quad_slot_next = '0;
                        c0x_next = '0;  c0y_next = '0;  c1x_next = '0;  c1y_next = '0;
                        edge_a_next = '0;  line_off_next = '0;
                    end
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            sel_reg <= 1'b0;
            quad_slot_reg <= '0;
            c0x_reg <= '0;  c0y_reg <= '0;  c1x_reg <= '0;  c1y_reg <= '0;
            edge_a_reg <= '0;  line_off_reg <= '0;
            map_mode_reg <= MODE_INSTANCE;
            origin_x_reg <= '0;  origin_y_reg <= '0;
            tex_height_reg <= '0;
            scale_x_reg <= W'({1'b1, {F{1'b0}}});
            scale_y_reg <= W'({1'b1, {F{1'b0}}});
            offset_x_reg <= '0;  offset_y_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            sel_reg <= sel_next;
            quad_slot_reg <= quad_slot_next;
            c0x_reg <= c0x_next;  c0y_reg <= c0y_next;
            c1x_reg <= c1x_next;  c1y_reg <= c1y_next;
            edge_a_reg <= edge_a_next;  line_off_reg <= line_off_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_MAP_MODE:   map_mode_reg <= cfg_wdata[1:0];
                    REG_ORIGIN_X:   origin_x_reg <= cfg_wdata;
                    REG_ORIGIN_Y:   origin_y_reg <= cfg_wdata;
                    REG_TEX_HEIGHT: tex_height_reg <= cfg_wdata[TEX_BITS-1:0];
                    REG_SCALE_X:    scale_x_reg <= cfg_wdata;
                    REG_SCALE_Y:    scale_y_reg <= cfg_wdata;
                    REG_OFFSET_X:   offset_x_reg <= cfg_wdata;
                    REG_OFFSET_Y:   offset_y_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
        last_reg <= last_next;  fault_reg <= fault_next;  slot_cur_reg <= slot_cur_next;
        nu_reg <= nu_next;  nv_reg <= nv_next;
        mx_reg <= mx_next;  my_reg <= my_next;  dxm_reg <= dxm_next;  dym_reg <= dym_next;
        acc_reg <= acc_next;  rem_reg <= rem_next;  root_reg <= root_next;
        dvd_reg <= dvd_next;  rmd_reg <= rmd_next;  quo_reg <= quo_next;
        dsr_reg <= dsr_next;  big_reg <= big_next;  neg_reg <= neg_next;  anz_reg <= anz_next;
        u_reg <= u_next;  v_reg <= v_next;
    end

endmodule

// ===== rtl/core/tcg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcg_protocol_check
// Port-level checks for the texture coordinate generator, bound to the core.
// ----------------------------------------------------------------------------
module tcg_protocol_check #(
    parameter int WORD_BITS = tcg_pkg::DEF_WORD_BITS
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [((2*WORD_BITS+7)/8)*8-1:0] m_tdata,
    input logic                             m_tlast,
    input logic                             m_tuser
);

    // A stalled result beat must hold its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result beat changed");

    // Only one vertex is in flight, so input and output are never open together.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready stayed high after an accepted beat");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> s_tready && !m_tvalid)
        else $error("block did not return to idle after a result beat");

endmodule

bind texture_coordinate_generator_core tcg_protocol_check #(.WORD_BITS(WORD_BITS)) u_tcg_check (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
);

// ===== tb/sv/tcg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcg_checker
// Watches the configuration port and both stream channels of the texture
// coordinate generator, keeps its own copy of the registers and quad state,
// predicts one coordinate per accepted vertex and compares each result beat
// with the oldest prediction.
// ----------------------------------------------------------------------------
module tcg_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tlast,
    input  logic        m_tuser,
    output int          mismatches,
    output int          outstanding
);
    import tcg_pkg::*;

    typedef struct {
        logic [31:0] u;
        logic [31:0] v;
        bit          last;
        bit          fault;
    } coord_t;

    localparam longint MAXMAG = 64'sh8000_0000;

    coord_t      coord_q[$];
    logic [1:0]  mode_r;
    logic [31:0] org_x, org_y, scl_x, scl_y, off_x, off_y;
    logic [15:0] height_r;
    int          corner;
    longint      c0x, c0y, c1x, c1y, len_a, run_u;

    assign outstanding = coord_q.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic logic [127:0] magnitude(input longint v);
        return (v < 0) ? 128'(-v) : 128'(v);
    endfunction

    function automatic longint edge_length(input longint x0, input longint y0,
                                           input longint x1, input longint y1);
        logic [127:0] dx, dy, sq, root, c;
        dx = magnitude(x1 - x0);
        dy = magnitude(y1 - y0);
        sq = dx * dx + dy * dy;
        root = 0;
        for (int b = 52; b >= 0; b--) begin
            c = root | (128'd1 << b);
            if (c * c <= sq) root = c;
        end
        if (root > 128'h7fff_ffff) root = 128'h7fff_ffff;
        return longint'(root[63:0]);
    endfunction

    function automatic logic [31:0] scale_offset(input longint num, input logic [31:0] sreg,
                                                 input logic [31:0] oreg, inout bit fault);
        longint       s, res, q;
        logic [127:0] a, sm, qq;
        s = longint'(signed'(sreg));
        if (s == 0) begin
            fault = 1;
            q = (num > 0) ? MAXMAG : ((num < 0) ? -MAXMAG : 0);
        end else begin
            a = magnitude(num);
            sm = magnitude(s);
            qq = (a << 16) / sm;
            if (qq > 128'h8000_0000) qq = 128'h8000_0000;
            q = ((num < 0) != (s < 0)) ? -longint'(qq[63:0]) : longint'(qq[63:0]);
        end
        res = q + longint'(signed'(oreg));
        if (res > MAXMAG - 1) res = MAXMAG - 1;
        if (res < -MAXMAG) res = -MAXMAG;
        return res[31:0];
    endfunction

    function automatic coord_t predict_coord(input logic [63:0] data, input bit last);
        coord_t r;
        longint px, py, nu, nv, d, texv;
        bit     fault;
        px = longint'(signed'(data[31:0]));
        py = longint'(signed'(data[63:32]));
        fault = 0;
        texv = longint'(height_r) << 16;
        if (mode_r == MODE_INSTANCE) begin
            nu = px;
            nv = py;
        end else if (mode_r == MODE_LINE) begin
            case (corner)
                0: begin
                    c0x = px; c0y = py;
                    nu = run_u; nv = 0;
                end
                1: begin
                    c1x = px; c1y = py;
                    nu = run_u; nv = texv;
                end
                2: begin
                    len_a = edge_length(c0x, c0y, px, py);
                    nu = run_u + len_a; nv = 0;
                end
                default: begin
                    d = edge_length(c1x, c1y, px, py);
                    nu = run_u + d; nv = texv;
                    run_u += (d < len_a) ? d : len_a;
                    if (run_u > MAXMAG - 1) run_u = MAXMAG - 1;
                end
            endcase
            corner = (corner + 1) % 4;
        end else begin
            nu = px + longint'(signed'(org_x));
            nv = py + longint'(signed'(org_y));
        end
        r.u = scale_offset(nu, scl_x, off_x, fault);
        r.v = scale_offset(nv, scl_y, off_y, fault);
        r.last = last;
        r.fault = fault;
        return r;
    endfunction

    function automatic void clear_quad();
        corner = 0;
        c0x = 0; c0y = 0; c1x = 0; c1y = 0;
        len_a = 0; run_u = 0;
    endfunction

    initial mismatches = 0;

    always @(posedge aclk) begin
        coord_t want;
        if (!aresetn) begin
            mode_r = MODE_INSTANCE;
            org_x = 0; org_y = 0; height_r = 0;
            scl_x = 32'h0001_0000; scl_y = 32'h0001_0000;
            off_x = 0; off_y = 0;
            clear_quad();
            coord_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_MAP_MODE:   mode_r = cfg_wdata[1:0];
                    REG_ORIGIN_X:   org_x = cfg_wdata;
                    REG_ORIGIN_Y:   org_y = cfg_wdata;
                    REG_TEX_HEIGHT: height_r = cfg_wdata[15:0];
                    REG_SCALE_X:    scl_x = cfg_wdata;
                    REG_SCALE_Y:    scl_y = cfg_wdata;
                    REG_OFFSET_X:   off_x = cfg_wdata;
                    default:        off_y = cfg_wdata;
                endcase
            end
            if (s_tvalid && s_tready) begin
                coord_q.push_back(predict_coord(s_tdata, s_tlast));
                if (s_tlast) clear_quad();
            end
            if (m_tvalid && m_tready) begin
                if (coord_q.size() == 0) begin
                    report("unexpected beat", m_tdata[31:0], 32'h0);
                end else begin
                    want = coord_q.pop_front();
                    if (m_tdata[31:0] !== want.u) report("tex_u", m_tdata[31:0], want.u);
                    if (m_tdata[63:32] !== want.v) report("tex_v", m_tdata[63:32], want.v);
                    if (m_tlast !== want.last) report("end_of_mesh_out", 32'(m_tlast), 32'(want.last));
                    if (m_tuser !== want.fault) report("divide_fault", 32'(m_tuser), 32'(want.fault));
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the texture coordinate generator: directed extremes of every
// mapping mode, zero and negative scales and a partial quad, then random
// meshes under many register settings with random idling on both sides and
// one long receiver hold-off. The checker does the comparison.
// ----------------------------------------------------------------------------
module tb_top;
    import tcg_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = REG_MAP_MODE;
    logic [31:0] cfg_wdata = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [63:0] s_tdata = 0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    int          mismatches;
    int          outstanding;
    int          cycle = 0;
    int          hold_cnt = 0;
    logic [31:0] regs [8];

    localparam logic [31:0] W_MAX = 32'h7fff_ffff;
    localparam logic [31:0] W_MIN = 32'h8000_0000;
    localparam logic [31:0] ONE   = 32'h0001_0000;

    texture_coordinate_generator_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    tcg_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser), .mismatches(mismatches), .outstanding(outstanding)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic bit quiet();
        return cycle >= 80000 && cycle < 160000;
    endfunction

    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (!aresetn) begin
            m_tready <= 0;
        end else if (cycle == 30000) begin
            hold_cnt <= 3000;
            m_tready <= 0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 0;
        end else begin
            m_tready <= quiet() || ($urandom_range(99) >= 6);
        end
    end

    task automatic program_regs();
        for (int i = 0; i < 8; i++) begin
            cfg_we <= 1;
            cfg_index <= 3'(i);
            cfg_wdata <= regs[i];
            @(posedge aclk);
        end
        cfg_we <= 0;
    endtask

    task automatic send_vertex(input logic [31:0] x, input logic [31:0] y, input bit last);
        if (!quiet() && $urandom_range(99) < 6) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {y, x};
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (outstanding != 0) @(negedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return W_MAX;
            1: return W_MIN;
            2: return 0;
            3: return 32'($urandom_range(0, 1 << 21)) - (1 << 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_scale();
        logic [31:0] s;
        case ($urandom_range(0, 9))
            0: return 0;
            1: return W_MAX;
            2: return W_MIN;
            3: return $urandom;
            default: begin
                s = 32'($urandom_range(1 << 12, 1 << 19));
                return $urandom_range(1) ? -s : s;
            end
        endcase
    endfunction

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 9))
            0: return W_MAX;
            1: return W_MIN;
            2, 3, 4: return $urandom;
            default: return 32'($urandom_range(0, 1 << 22)) - (1 << 21);
        endcase
    endfunction

    initial begin
        int mesh_len;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Reset settings: instance mode with unit scale.
        send_vertex(W_MAX, W_MIN, 0);
        send_vertex(W_MIN, W_MAX, 0);
        send_vertex(0, 0, 1);
        send_vertex(32'hffff_ffff, 1, 0);
        drain();

        // World mode with extreme origins, a zero and a tiny negative scale.
        regs = '{32'(MODE_WORLD), W_MAX, W_MIN, 16'hffff, 0, 32'hffff_ffff, W_MIN, W_MAX};
        program_regs();
        send_vertex(W_MAX, W_MIN, 0);
        send_vertex(0, 0, 0);
        send_vertex(W_MIN, W_MAX, 1);
        drain();
        regs[0] = 3;
        program_regs();
        send_vertex(1, 32'hffff_ffff, 0);
        send_vertex(W_MIN, W_MIN, 1);
        drain();

        // Line mode: extreme corners, a second quad and a partial last quad.
        regs = '{32'(MODE_LINE), 0, 0, 16'hffff, ONE, ONE, 0, 0};
        program_regs();
        send_vertex(W_MIN, W_MIN, 0);
        send_vertex(W_MIN, W_MAX, 0);
        send_vertex(W_MAX, W_MAX, 0);
        send_vertex(W_MAX, W_MIN, 0);
        send_vertex(0, 0, 0);
        send_vertex(ONE, 0, 0);
        send_vertex(0, 3 * ONE, 0);
        send_vertex(ONE, 4 * ONE, 0);
        send_vertex(5, 7, 0);
        send_vertex(9, 11, 1);
        drain();

        for (int ph = 0; ph < 16; ph++) begin
            case ($urandom_range(0, 4))
                0: regs[0] = 32'(MODE_WORLD);
                1: regs[0] = 32'(MODE_INSTANCE);
                2: regs[0] = 3;
                default: regs[0] = 32'(MODE_LINE);
            endcase
            regs[1] = rand_word();
            regs[2] = rand_word();
            case ($urandom_range(0, 3))
                0: regs[3] = 0;
                1: regs[3] = 16'hffff;
                default: regs[3] = $urandom_range(0, 16'hffff);
            endcase
            regs[4] = rand_scale();
            regs[5] = rand_scale();
            regs[6] = rand_word();
            regs[7] = rand_word();
            program_regs();
            for (int n = 0; n < 106; n += mesh_len) begin
                mesh_len = $urandom_range(1, 13);
                for (int k = 0; k < mesh_len; k++)
                    send_vertex(rand_pos(), rand_pos(), k == mesh_len - 1);
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/tcg_pkg.sv
rtl/core/texture_coordinate_generator_core.sv
rtl/core/tcg_checker.sv
tb/sv/tcg_checker.sv
tb/sv/tb_top.sv
